// ===== rtl/tck_pkg.sv =====
package tck_pkg;

    localparam int TCK_ENTRIES = 88;
    localparam int TCK_IDX_W   = $clog2(TCK_ENTRIES);

    localparam int TEMP_W     = 12;
    localparam int EMF_W      = 18;
    localparam int KEY_W      = EMF_W;
    localparam int DIFF_W     = KEY_W + 1;
    localparam int ACC_W      = 26;
    localparam int DIV_W      = ACC_W + 1;
    localparam int DVS_W      = DIFF_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMF_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMF_HIGH  = 2'd3;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = -12'sd270;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 12'sd1372;
    localparam logic signed [EMF_W-1:0]  EMF_LOW_RST   = -18'sd6458;
    localparam logic signed [EMF_W-1:0]  EMF_HIGH_RST  = 18'sd54886;

    localparam logic CMD_T2E = 1'b0;
    localparam logic CMD_E2T = 1'b1;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;

    typedef struct packed {
        logic signed [TEMP_W-1:0] deg;
        logic signed [EMF_W-1:0]  uv;
    } tck_point_t;

    typedef struct packed {
        logic                     command;
        logic signed [TEMP_W-1:0] temp_in;
        logic signed [EMF_W-1:0]  emf_in_uv;
    } tck_item_t;

    typedef struct packed {
        logic                     status;
        logic signed [EMF_W-1:0]  emf_out_uv;
        logic signed [TEMP_W-1:0] temp_out;
    } tck_result_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_low;
        logic signed [TEMP_W-1:0] temp_high;
        logic signed [EMF_W-1:0]  emf_low;
        logic signed [EMF_W-1:0]  emf_high;
    } tck_limits_t;

    function automatic tck_point_t tck_point(input logic [TCK_IDX_W-1:0] idx);
        int d;
        int u;
        tck_point_t p;
        case (idx)
            0:  begin d = -270; u = -6458; end    1:  begin d = -260; u = -6441; end
            2:  begin d = -250; u = -6404; end    3:  begin d = -240; u = -6344; end
            4:  begin d = -230; u = -6262; end    5:  begin d = -220; u = -6158; end
            6:  begin d = -210; u = -6035; end    7:  begin d = -200; u = -5891; end
            8:  begin d = -190; u = -5730; end    9:  begin d = -180; u = -5550; end
            10: begin d = -170; u = -5354; end    11: begin d = -160; u = -5141; end
            12: begin d = -150; u = -4913; end    13: begin d = -140; u = -4669; end
            14: begin d = -130; u = -4411; end    15: begin d = -120; u = -4138; end
            16: begin d = -110; u = -3852; end    17: begin d = -100; u = -3554; end
            18: begin d = -90;  u = -3243; end    19: begin d = -80;  u = -2920; end
            20: begin d = -70;  u = -2587; end    21: begin d = -60;  u = -2243; end
            22: begin d = -50;  u = -1889; end    23: begin d = -40;  u = -1527; end
            24: begin d = -30;  u = -1156; end    25: begin d = -20;  u = -778;  end
            26: begin d = -10;  u = -392;  end    27: begin d = 0;    u = 0;     end
            28: begin d = 10;   u = 397;   end    29: begin d = 20;   u = 798;   end
            30: begin d = 30;   u = 1203;  end    31: begin d = 40;   u = 1612;  end
            32: begin d = 50;   u = 2023;  end    33: begin d = 60;   u = 2436;  end
            34: begin d = 70;   u = 2851;  end    35: begin d = 80;   u = 3267;  end
            36: begin d = 90;   u = 3682;  end    37: begin d = 100;  u = 4096;  end
            38: begin d = 110;  u = 4509;  end    39: begin d = 120;  u = 4920;  end
            40: begin d = 130;  u = 5328;  end    41: begin d = 140;  u = 5735;  end
            42: begin d = 150;  u = 6138;  end    43: begin d = 160;  u = 6540;  end
            44: begin d = 170;  u = 6941;  end    45: begin d = 180;  u = 7340;  end
            46: begin d = 190;  u = 7739;  end    47: begin d = 200;  u = 8138;  end
            48: begin d = 210;  u = 8539;  end    49: begin d = 220;  u = 8940;  end
            50: begin d = 230;  u = 9343;  end    51: begin d = 240;  u = 9747;  end
            52: begin d = 250;  u = 10153; end    53: begin d = 260;  u = 10561; end
            54: begin d = 270;  u = 10971; end    55: begin d = 280;  u = 11382; end
            56: begin d = 290;  u = 11795; end    57: begin d = 300;  u = 12209; end
            58: begin d = 310;  u = 12624; end    59: begin d = 320;  u = 13040; end
            60: begin d = 330;  u = 13457; end    61: begin d = 340;  u = 13874; end
            62: begin d = 350;  u = 14293; end    63: begin d = 360;  u = 14713; end
            64: begin d = 370;  u = 15133; end    65: begin d = 380;  u = 15554; end
            66: begin d = 390;  u = 15975; end    67: begin d = 400;  u = 16397; end
            68: begin d = 450;  u = 18516; end    69: begin d = 500;  u = 20644; end
            70: begin d = 550;  u = 22776; end    71: begin d = 600;  u = 24905; end
            72: begin d = 650;  u = 27025; end    73: begin d = 700;  u = 29129; end
            74: begin d = 750;  u = 31213; end    75: begin d = 800;  u = 33275; end
            76: begin d = 850;  u = 35313; end    77: begin d = 900;  u = 37326; end
            78: begin d = 950;  u = 39314; end    79: begin d = 1000; u = 41276; end
            80: begin d = 1050; u = 43211; end    81: begin d = 1100; u = 45119; end
            82: begin d = 1150; u = 46995; end    83: begin d = 1200; u = 48838; end
            84: begin d = 1250; u = 50644; end    85: begin d = 1300; u = 52410; end
            86: begin d = 1350; u = 54138; end    87: begin d = 1372; u = 54886; end
            default: begin d = 0; u = 0; end
        endcase
        p.deg = TEMP_W'(d);
        p.uv  = EMF_W'(u);
        return p;
    endfunction

    function automatic logic signed [KEY_W-1:0] tck_col(input tck_point_t p, input logic by_uv);
        return by_uv ? p.uv : KEY_W'(p.deg);
    endfunction

endpackage

// ===== rtl/tck_div.sv =====
module tck_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tck_pkg::DIV_W-1:0]      dividend,
    input  logic [tck_pkg::DVS_W-1:0]      divisor,
    output logic                           done,
    output logic [tck_pkg::DIV_W-1:0]      quotient
);

    localparam int DW = tck_pkg::DIV_W;
    localparam int VW = tck_pkg::DVS_W;
    localparam int CW = tck_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW:0]   rem_shift;
    logic          fits;
    logic [VW-1:0] rem_next;

    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_next  = fits ? VW'(rem_shift - {1'b0, dvs_reg}) : VW'(rem_shift);
    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/tck_core.sv =====
module tck_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tck_pkg::tck_item_t    in_item,
    input  tck_pkg::tck_limits_t  limits,
    output logic                  res_valid,
    input  logic                  res_ready,
    output tck_pkg::tck_result_t  result
);

    localparam int IW  = tck_pkg::TCK_IDX_W;
    localparam int KW  = tck_pkg::KEY_W;
    localparam int FW  = tck_pkg::DIFF_W;
    localparam int AW  = tck_pkg::ACC_W;
    localparam int DW  = tck_pkg::DIV_W;
    localparam int VW  = tck_pkg::DVS_W;
    localparam int EW  = tck_pkg::EMF_W;
    localparam int TW  = tck_pkg::TEMP_W;
    localparam logic [DW-1:0] EMF_POS_MAX  = DW'(2 ** (EW - 1) - 1);
    localparam logic [DW-1:0] TEMP_POS_MAX = DW'(2 ** (TW - 1) - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_SEARCH = 8'b0000_0100,
        S_MUL0   = 8'b0000_1000,
        S_MUL1   = 8'b0001_0000,
        S_DIVGO  = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } tck_state_t;

    tck_state_t state_reg, state_next;

    logic                 cmd_reg;
    logic signed [KW-1:0] key_reg;
    logic [IW-1:0]        lo_reg, hi_reg;
    logic signed [FW-1:0] den_reg, dx_reg, dy_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 neg_reg;
    tck_pkg::tck_result_t res_reg, res_next;

    logic [IW-1:0]          mid;
    tck_pkg::tck_point_t    p0, p1;
    logic signed [KW-1:0]   x0, x1, y0, y1, probe, key_in, low_lim, high_lim;
    logic                   in_range, span_open;
    logic signed [FW-1:0]   mul_a, mul_b;
    logic signed [2*FW-1:0] mul_p;
    logic signed [AW-1:0]   acc_mag;
    logic                   div_start, div_done;
    logic [DW-1:0]          div_dvd, quo, q_lim, q_sat, r_full;
    logic [VW-1:0]          div_dvs;

    assign key_in = (in_item.command == tck_pkg::CMD_E2T) ? in_item.emf_in_uv
                                                           : KW'(in_item.temp_in);

    assign low_lim  = (cmd_reg == tck_pkg::CMD_E2T) ? limits.emf_low  : KW'(limits.temp_low);
    assign high_lim = (cmd_reg == tck_pkg::CMD_E2T) ? limits.emf_high : KW'(limits.temp_high);
    assign in_range = (key_reg >= low_lim) && (key_reg <= high_lim);

    assign mid       = IW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign span_open = (hi_reg - lo_reg) > IW'(1);
    assign probe     = tck_pkg::tck_col(tck_pkg::tck_point(mid), cmd_reg);

    assign p0 = tck_pkg::tck_point(lo_reg);
    assign p1 = tck_pkg::tck_point(IW'(lo_reg + 1'b1));
    assign x0 = tck_pkg::tck_col(p0, cmd_reg);
    assign x1 = tck_pkg::tck_col(p1, cmd_reg);
    assign y0 = tck_pkg::tck_col(p0, !cmd_reg);
    assign y1 = tck_pkg::tck_col(p1, !cmd_reg);

    // Shared multiplier: y0 * den, then dy * dx
    always_comb
    begin
        if (state_reg == S_MUL1)
        begin
            mul_a = dy_reg;
            mul_b = dx_reg;
        end
        else
        begin
            mul_a = FW'(y0);
            mul_b = den_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Round half away from zero: (2|t| + den) / (2 den)
    assign acc_mag   = acc_reg[AW-1] ? -acc_reg : acc_reg;
    assign div_dvd   = {acc_mag, 1'b0} + DW'(den_reg);
    assign div_dvs   = {den_reg, 1'b0};
    assign div_start = (state_reg == S_DIVGO);

    tck_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quo)
    );

    // Saturate to the output field, then restore the sign
    always_comb
    begin
        q_lim = ((cmd_reg == tck_pkg::CMD_E2T) ? TEMP_POS_MAX : EMF_POS_MAX) + DW'(neg_reg);
        q_sat = (quo > q_lim) ? q_lim : quo;
        r_full = neg_reg ? -q_sat : q_sat;
        res_next.status     = tck_pkg::STAT_OK;
        res_next.emf_out_uv = (cmd_reg == tck_pkg::CMD_E2T) ? '0 : r_full[EW-1:0];
        res_next.temp_out   = (cmd_reg == tck_pkg::CMD_E2T) ? r_full[TW-1:0] : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_CHECK;
            S_CHECK:  state_next = in_range ? S_SEARCH : S_DONE;
            S_SEARCH: if (!span_open) state_next = S_MUL0;
            S_MUL0:   state_next = S_MUL1;
            S_MUL1:   state_next = S_DIVGO;
            S_DIVGO:  state_next = S_DIV;
            S_DIV:    if (div_done) state_next = S_DONE;
            S_DONE:   if (res_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg <= in_item.command;
                    key_reg <= key_in;
                    lo_reg  <= '0;
                    hi_reg  <= IW'(tck_pkg::TCK_ENTRIES - 1);
                end
            end
            S_CHECK:
            begin
                if (!in_range)
                begin
                    res_reg.status     <= tck_pkg::STAT_RANGE;
                    res_reg.emf_out_uv <= '0;
                    res_reg.temp_out   <= '0;
                end
            end
            S_SEARCH:
            begin
                if (span_open)
                begin
                    if (probe <= key_reg)
                        lo_reg <= mid;
                    else
                        hi_reg <= mid;
                end
                else
                begin
                    den_reg <= FW'(x1) - FW'(x0);
                    dx_reg  <= FW'(key_reg) - FW'(x0);
                    dy_reg  <= FW'(y1) - FW'(y0);
                end
            end
            S_MUL0:  acc_reg <= AW'(mul_p);
            S_MUL1:  acc_reg <= acc_reg + AW'(mul_p);
            S_DIVGO: neg_reg <= acc_reg[AW-1];
            S_DIV:   if (div_done) res_reg <= res_next;
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign result    = res_reg;

endmodule

// ===== rtl/thermocouple_k_table_interpolator_unit.sv =====
// Type K thermocouple converter, temperature to EMF and EMF to temperature.
// Input stream s_*: s_tuser selects the direction (0: degrees to microvolts,
// 1: microvolts to degrees); s_tdata carries both operands.
// Output stream m_*: m_tuser is the status (1: operand outside the limits,
// data zero); m_tdata carries the converted value in the field of its kind.
// Config channel cfg_*: index 0..3 writes the temperature low/high and the
// EMF low/high limits; always ready, write only between conversions.
// A conversion in range runs six or seven table probes of the binary search
// (one per cycle), two passes through the shared multiplier and a 27-step
// restoring divider; a rejected word skips these steps and goes straight to
// its result.
// One word is in flight at a time; s_tready stays low until the result
// leaves the converter for the output register, so a new word is not taken
// before the result of the last one has left the converter.
// A stalled receiver holds the output register; the next word is still
// accepted and converted, and waits for the register to drain.
// Reset clears both streams and loads the default Type K limits.
module thermocouple_k_table_interpolator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tck_pkg::IN_DATA_W-1:0]       s_tdata,   // temp_in, emf_in_uv
    input  logic [0:0]                          s_tuser,   // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tck_pkg::OUT_DATA_W-1:0]      m_tdata,   // emf_out_uv, temp_out
    output logic [0:0]                          m_tuser,   // status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tck_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tck_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int TW = tck_pkg::TEMP_W;
    localparam int EW = tck_pkg::EMF_W;

    logic signed [TW-1:0] temp_low_reg, temp_high_reg;
    logic signed [EW-1:0] emf_low_reg, emf_high_reg;
    tck_pkg::tck_limits_t limits;
    tck_pkg::tck_item_t   in_item;
    tck_pkg::tck_result_t core_res, out_res_reg;
    logic                 res_valid, res_ready;
    logic                 out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg  <= tck_pkg::TEMP_LOW_RST;
            temp_high_reg <= tck_pkg::TEMP_HIGH_RST;
            emf_low_reg   <= tck_pkg::EMF_LOW_RST;
            emf_high_reg  <= tck_pkg::EMF_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tck_pkg::CFG_TEMP_LOW:  temp_low_reg  <= cfg_data[TW-1:0];
                tck_pkg::CFG_TEMP_HIGH: temp_high_reg <= cfg_data[TW-1:0];
                tck_pkg::CFG_EMF_LOW:   emf_low_reg   <= cfg_data[EW-1:0];
                tck_pkg::CFG_EMF_HIGH:  emf_high_reg  <= cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    assign limits.temp_low  = temp_low_reg;
    assign limits.temp_high = temp_high_reg;
    assign limits.emf_low   = emf_low_reg;
    assign limits.emf_high  = emf_high_reg;

    assign in_item.command   = s_tuser[0];
    assign in_item.temp_in   = s_tdata[TW-1:0];
    assign in_item.emf_in_uv = s_tdata[TW+EW-1:TW];

    tck_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .limits    (limits),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (core_res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = tck_pkg::OUT_DATA_W'({out_res_reg.temp_out, out_res_reg.emf_out_uv});

`ifndef NO_ASSERTIONS
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(core_res))
        else $error("converter result changed while waiting for the output register");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting a word");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("rejected word carries nonzero data");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("output word appeared without a converter result");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 50;
    localparam int TW          = tck_pkg::TEMP_W;
    localparam int EW          = tck_pkg::EMF_W;
    localparam int NE          = tck_pkg::TCK_ENTRIES;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [tck_pkg::IN_DATA_W-1:0]      s_tdata = '0;
    logic [0:0]                         s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [tck_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic [0:0]                         m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [tck_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [tck_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    int tbl_deg [NE] = '{
        -270, -260, -250, -240, -230, -220, -210, -200, -190, -180,
        -170, -160, -150, -140, -130, -120, -110, -100, -90, -80,
        -70, -60, -50, -40, -30, -20, -10,
        0, 10, 20, 30, 40, 50, 60, 70, 80, 90,
        100, 110, 120, 130, 140, 150, 160, 170, 180, 190,
        200, 210, 220, 230, 240, 250, 260, 270, 280, 290,
        300, 310, 320, 330, 340, 350, 360, 370, 380, 390,
        400, 450, 500, 550, 600, 650, 700, 750, 800, 850,
        900, 950, 1000, 1050, 1100, 1150, 1200, 1250, 1300, 1350,
        1372
    };
    int tbl_uv [NE] = '{
        -6458, -6441, -6404, -6344, -6262, -6158, -6035, -5891, -5730, -5550,
        -5354, -5141, -4913, -4669, -4411, -4138, -3852, -3554, -3243, -2920,
        -2587, -2243, -1889, -1527, -1156, -778, -392,
        0, 397, 798, 1203, 1612, 2023, 2436, 2851, 3267, 3682,
        4096, 4509, 4920, 5328, 5735, 6138, 6540, 6941, 7340, 7739,
        8138, 8539, 8940, 9343, 9747, 10153, 10561, 10971, 11382, 11795,
        12209, 12624, 13040, 13457, 13874, 14293, 14713, 15133, 15554, 15975,
        16397, 18516, 20644, 22776, 24905, 27025, 29129, 31213, 33275, 35313,
        37326, 39314, 41276, 43211, 45119, 46995, 48838, 50644, 52410, 54138,
        54886
    };

    int lim_temp_lo = -270;
    int lim_temp_hi = 1372;
    int lim_emf_lo  = -6458;
    int lim_emf_hi  = 54886;

    tck_pkg::tck_result_t due_results[$];
    tck_pkg::tck_result_t obs_word;
    tck_pkg::tck_result_t due_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int fail_cnt      = 0;
    int cycle_cnt     = 0;

    thermocouple_k_table_interpolator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int lower_segment(input int key, input logic by_uv);
        int lo;
        int hi;
        int mid;
        int v;
        lo = 0;
        hi = NE - 1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            v = by_uv ? tbl_uv[mid] : tbl_deg[mid];
            if (v <= key)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic longint interp(input longint x0, input longint y0,
                                      input longint x1, input longint y1,
                                      input longint x);
        longint den;
        longint num;
        den = x1 - x0;
        num = y0 * den + (y1 - y0) * (x - x0);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic tck_pkg::tck_result_t k_convert(input tck_pkg::tck_item_t it);
        tck_pkg::tck_result_t r;
        int t;
        int e;
        int i;
        r.status     = tck_pkg::STAT_OK;
        r.emf_out_uv = '0;
        r.temp_out   = '0;
        t = it.temp_in;
        e = it.emf_in_uv;
        if (it.command == tck_pkg::CMD_T2E)
        begin
            if (t < lim_temp_lo || t > lim_temp_hi)
                r.status = tck_pkg::STAT_RANGE;
            else
            begin
                i = lower_segment(t, 1'b0);
                r.emf_out_uv = EW'(clamp(interp(tbl_deg[i], tbl_uv[i], tbl_deg[i+1],
                                                tbl_uv[i+1], t), -131072, 131071));
            end
        end
        else
        begin
            if (e < lim_emf_lo || e > lim_emf_hi)
                r.status = tck_pkg::STAT_RANGE;
            else
            begin
                i = lower_segment(e, 1'b1);
                r.temp_out = TW'(clamp(interp(tbl_uv[i], tbl_deg[i], tbl_uv[i+1],
                                              tbl_deg[i+1], e), -2048, 2047));
            end
        end
        return r;
    endfunction

    // receiver: hold off on request, else stall at random
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            obs_word.status     = m_tuser[0];
            obs_word.emf_out_uv = m_tdata[EW-1:0];
            obs_word.temp_out   = m_tdata[EW+TW-1:EW];
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected word status=%0d emf=%0d temp=%0d", $time,
                         obs_word.status, obs_word.emf_out_uv, obs_word.temp_out);
                fail_cnt++;
            end
            else
            begin
                due_word = due_results.pop_front();
                if (obs_word.status !== due_word.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             due_word.status, obs_word.status);
                    fail_cnt++;
                end
                if (obs_word.emf_out_uv !== due_word.emf_out_uv)
                begin
                    $display("%0t: emf_out_uv expected %0d actual %0d", $time,
                             due_word.emf_out_uv, obs_word.emf_out_uv);
                    fail_cnt++;
                end
                if (obs_word.temp_out !== due_word.temp_out)
                begin
                    $display("%0t: temp_out expected %0d actual %0d", $time,
                             due_word.temp_out, obs_word.temp_out);
                    fail_cnt++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge with the word taken
    task automatic send_word(input tck_pkg::tck_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.command;
        s_tdata  = tck_pkg::IN_DATA_W'({it.emf_in_uv, it.temp_in});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_results.push_back(k_convert(it));
        @(negedge clk);
    endtask

    task automatic send_conv(input logic cmd, input int t, input int e);
        tck_pkg::tck_item_t it;
        it.command   = cmd;
        it.temp_in   = TW'(t);
        it.emf_in_uv = EW'(e);
        send_word(it);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [tck_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = tck_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tck_pkg::CFG_TEMP_LOW:  lim_temp_lo = $signed(cfg_data[TW-1:0]);
            tck_pkg::CFG_TEMP_HIGH: lim_temp_hi = $signed(cfg_data[TW-1:0]);
            tck_pkg::CFG_EMF_LOW:   lim_emf_lo  = $signed(cfg_data);
            tck_pkg::CFG_EMF_HIGH:  lim_emf_hi  = $signed(cfg_data);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input int t_lo, input int t_hi, input int e_lo, input int e_hi);
        write_limit(tck_pkg::CFG_TEMP_LOW, t_lo);
        write_limit(tck_pkg::CFG_TEMP_HIGH, t_hi);
        write_limit(tck_pkg::CFG_EMF_LOW, e_lo);
        write_limit(tck_pkg::CFG_EMF_HIGH, e_hi);
    endtask

    function automatic tck_pkg::tck_item_t rand_item();
        tck_pkg::tck_item_t it;
        int sel;
        int k;
        it.command   = $urandom_range(1, 0);
        it.temp_in   = TW'($urandom);
        it.emf_in_uv = EW'($urandom);
        sel = $urandom_range(99);
        k   = $urandom_range(NE - 1);
        if (sel < 25)
        begin
            it.temp_in   = TW'(tbl_deg[k] + int'($urandom_range(2)) - 1);
            it.emf_in_uv = EW'(tbl_uv[k] + int'($urandom_range(2)) - 1);
        end
        else if (sel < 85)
        begin
            if (lim_temp_lo <= lim_temp_hi)
                it.temp_in = TW'(lim_temp_lo +
                                 int'($urandom_range(lim_temp_hi - lim_temp_lo)));
            if (lim_emf_lo <= lim_emf_hi)
                it.emf_in_uv = EW'(lim_emf_lo +
                                   int'($urandom_range(lim_emf_hi - lim_emf_lo)));
        end
        return it;
    endfunction

    task automatic test_directed();
        send_conv(tck_pkg::CMD_T2E, -270, 0);
        send_conv(tck_pkg::CMD_T2E, 1372, 0);
        send_conv(tck_pkg::CMD_T2E, 0, 0);
        send_conv(tck_pkg::CMD_T2E, 25, 0);
        send_conv(tck_pkg::CMD_T2E, 401, 0);
        send_conv(tck_pkg::CMD_T2E, 1371, 0);
        send_conv(tck_pkg::CMD_T2E, -271, 0);
        send_conv(tck_pkg::CMD_T2E, 1373, 0);
        send_conv(tck_pkg::CMD_T2E, -2048, -131072);
        send_conv(tck_pkg::CMD_T2E, 2047, 131071);
        send_conv(tck_pkg::CMD_E2T, 0, -6458);
        send_conv(tck_pkg::CMD_E2T, 0, 54886);
        send_conv(tck_pkg::CMD_E2T, 0, 0);
        send_conv(tck_pkg::CMD_E2T, 0, 16397);
        send_conv(tck_pkg::CMD_E2T, 0, 1000);
        send_conv(tck_pkg::CMD_E2T, 0, -6459);
        send_conv(tck_pkg::CMD_E2T, 0, 54887);
        send_conv(tck_pkg::CMD_E2T, -2048, -131072);
        send_conv(tck_pkg::CMD_E2T, 2047, 131071);
        send_conv(tck_pkg::CMD_E2T, 0, 20);
        drain();
    endtask

    // limits beyond the table: extrapolate and saturate
    task automatic test_wide_limits();
        set_limits(-2048, 2047, -131072, 131071);
        send_conv(tck_pkg::CMD_T2E, -2048, 0);
        send_conv(tck_pkg::CMD_T2E, 2047, 0);
        send_conv(tck_pkg::CMD_T2E, -1000, 0);
        send_conv(tck_pkg::CMD_T2E, 1500, 0);
        send_conv(tck_pkg::CMD_E2T, 0, -131072);
        send_conv(tck_pkg::CMD_E2T, 0, 131071);
        send_conv(tck_pkg::CMD_E2T, 0, -10000);
        send_conv(tck_pkg::CMD_E2T, 0, 60000);
        drain();
    endtask

    task automatic test_crossed_limits();
        set_limits(100, -100, 1000, -1000);
        send_conv(tck_pkg::CMD_T2E, 0, 0);
        send_conv(tck_pkg::CMD_T2E, 100, 0);
        send_conv(tck_pkg::CMD_T2E, -100, 0);
        send_conv(tck_pkg::CMD_E2T, 0, 0);
        send_conv(tck_pkg::CMD_E2T, 0, 1000);
        send_conv(tck_pkg::CMD_E2T, 0, -1000);
        drain();
    endtask

    // stall the receiver long enough that the input side backs up
    task automatic test_backpressure();
        int n;
        set_limits(-270, 1372, -6458, 54886);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 400;
        for (n = 0; n < 8; n++)
            send_word(rand_item());
        drain();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct,
                               input bit use_reset_limits);
        int n;
        int t_lo;
        int e_lo;
        if (use_reset_limits)
            set_limits(tck_pkg::TEMP_LOW_RST, tck_pkg::TEMP_HIGH_RST,
                       tck_pkg::EMF_LOW_RST, tck_pkg::EMF_HIGH_RST);
        else
        begin
            t_lo = int'($urandom_range(900)) - 800;
            e_lo = int'($urandom_range(40000)) - 30000;
            set_limits(t_lo, int'(clamp(t_lo + int'($urandom_range(1900)), -2048, 2047)),
                       e_lo, e_lo + int'($urandom_range(90000)));
        end
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (n = 0; n < count; n++)
            send_word(rand_item());
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 47;
        test_directed();
        test_wide_limits();
        test_crossed_limits();
        test_backpressure();
        test_random(360, 30, 47, 1'b1);
        test_random(360, 47, 30, 1'b0);
        test_random(360, 0, 0, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
